@@ rtl/scl_pkg.sv @@
// ----------------------------------------------------------------------------
// scl_pkg
// shared types, limits and digit helpers for the settable clock block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

  localparam int unsigned SEG_W     = 7;
  localparam int unsigned LED_OUT_W = 10;

  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [5:0] MIN_LIMIT  = 6'd60;
  localparam logic [4:0] HOUR_LIMIT = 5'd24;

  // field selector carried on each item
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_SEC  = 2'd1,
    SEL_MIN  = 2'd2,
    SEL_HOUR = 2'd3
  } set_sel_e;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
  } time_t;

  typedef struct packed {
    logic [SEG_W-1:0]     seg_sec_ones;
    logic [SEG_W-1:0]     seg_sec_tens;
    logic [SEG_W-1:0]     seg_min_ones;
    logic [SEG_W-1:0]     seg_min_tens;
    logic [SEG_W-1:0]     seg_hour_ones;
    logic [SEG_W-1:0]     seg_hour_tens;
    logic [LED_OUT_W-1:0] led_pattern;
  } result_t;

  // active-low segments, bit 0 is segment a; anything above nine shows zero
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h10;
      default: code = 7'h40;
    endcase
    return code;
  endfunction

  // tens digit by reciprocal multiply, exact for all six-bit values
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd205;
    return prod[13:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] tens_x10;
    logic [5:0] diff;
    tens_x10 = 6'(tens_of(v)) * 6'd10;
    diff     = v - tens_x10;
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/scl_tick.sv @@
// ----------------------------------------------------------------------------
// scl_tick
// time and led ring state, advanced and optionally set once per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scl_tick #(
  parameter int unsigned LED_COUNT = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic                           rotate_left_i,
  input  wire logic [1:0]                     set_select_i,
  input  wire logic [6:0]                     set_value_i,
  output scl_pkg::time_t                      time_q_o,
  output scl_pkg::time_t                      time_d_o,
  output logic [scl_pkg::LED_OUT_W-1:0]       led_pattern_o
);
  import scl_pkg::*;

  localparam logic [LED_COUNT-1:0] LedInit = {LED_COUNT{1'b1}} << (LED_COUNT - 2);

  time_t                time_q, time_d, time_adv;
  logic [LED_COUNT-1:0] ring_q, ring_d;
  logic [5:0]           sec_inc, min_inc;
  logic [4:0]           hour_inc;
  set_sel_e             sel;

  assign sel = set_sel_e'(set_select_i);

  always_comb begin
    sec_inc  = time_q.sec + 6'd1;
    min_inc  = time_q.min + 6'd1;
    hour_inc = time_q.hour + 5'd1;
    time_adv = time_q;
    if (sec_inc >= SEC_LIMIT) begin
      time_adv.sec = '0;
      if (min_inc >= MIN_LIMIT) begin
        time_adv.min  = '0;
        time_adv.hour = (hour_inc >= HOUR_LIMIT) ? 5'd0 : hour_inc;
      end else begin
        time_adv.min = min_inc;
      end
    end else begin
      time_adv.sec = sec_inc;
    end

    time_d = time_adv;
    case (sel)
      SEL_SEC:  time_d.sec  = (set_value_i >= 7'(SEC_LIMIT))  ? 6'd0 : set_value_i[5:0];
      SEL_MIN:  time_d.min  = (set_value_i >= 7'(MIN_LIMIT))  ? 6'd0 : set_value_i[5:0];
      SEL_HOUR: time_d.hour = (set_value_i >= 7'(HOUR_LIMIT)) ? 5'd0 : set_value_i[4:0];
      default:  time_d = time_adv;
    endcase

    if (rotate_left_i) begin
      ring_d = {ring_q[LED_COUNT-2:0], ring_q[LED_COUNT-1]};
    end else begin
      ring_d = {ring_q[0], ring_q[LED_COUNT-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      ring_q <= LedInit;
    end else if (step_i) begin
      time_q <= time_d;
      ring_q <= ring_d;
    end
  end

  generate
    if (LED_COUNT >= LED_OUT_W) begin : g_led_trunc
      assign led_pattern_o = ring_q[LED_OUT_W-1:0];
    end else begin : g_led_ext
      assign led_pattern_o = {{(LED_OUT_W - LED_COUNT){1'b0}}, ring_q};
    end
  endgenerate

  assign time_q_o = time_q;
  assign time_d_o = time_d;

endmodule

`default_nettype wire

@@ rtl/scl_seg_decode.sv @@
// ----------------------------------------------------------------------------
// scl_seg_decode
// splits hh:mm:ss into digits and maps them to segment codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scl_seg_decode (
  input  wire scl_pkg::time_t                time_i,
  input  wire logic [scl_pkg::LED_OUT_W-1:0] led_pattern_i,
  output scl_pkg::result_t                  result_o
);
  import scl_pkg::*;

  logic [5:0] hour_w;

  assign hour_w = {1'b0, time_i.hour};

  always_comb begin
    result_o.seg_sec_ones  = seg_of(ones_of(time_i.sec));
    result_o.seg_sec_tens  = seg_of({1'b0, tens_of(time_i.sec)});
    result_o.seg_min_ones  = seg_of(ones_of(time_i.min));
    result_o.seg_min_tens  = seg_of({1'b0, tens_of(time_i.min)});
    result_o.seg_hour_ones = seg_of(ones_of(hour_w));
    result_o.seg_hour_tens = seg_of({1'b0, tens_of(hour_w)});
    result_o.led_pattern   = led_pattern_i;
  end

endmodule

`default_nettype wire

@@ rtl/scl_out_buf.sv @@
// ----------------------------------------------------------------------------
// scl_out_buf
// result register with a skid entry so input and output sides stay decoupled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scl_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire scl_pkg::result_t data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_ready_i,
  output scl_pkg::result_t      data_o,
  output logic                  skid_valid_o
);
  import scl_pkg::*;

  result_t main_q, skid_q;
  logic    main_v_q, skid_v_q;
  logic    pop;

  assign pop     = main_v_q && pop_ready_i;
  assign ready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (pop && skid_v_q) begin
        skid_v_q <= 1'b0;
      end else if (push_i && main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end
      if (push_i) begin
        main_v_q <= 1'b1;
      end else if (pop && !skid_v_q) begin
        main_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_v_q) begin
      main_q <= skid_q;
    end else if (push_i && (!main_v_q || pop)) begin
      main_q <= data_i;
    end
    if (push_i && main_v_q && !pop) begin
      skid_q <= data_i;
    end
  end

  assign valid_o      = main_v_q;
  assign data_o       = main_q;
  assign skid_valid_o = skid_v_q;

endmodule

`default_nettype wire

@@ rtl/settable_clock_with_led_rotator.sv @@
// ----------------------------------------------------------------------------
// settable_clock_with_led_rotator
// hh:mm:ss clock with per-item set and a rotating led ring, seven-seg out
// ----------------------------------------------------------------------------
// results register in the main entry, or in the skid entry while main waits
// throughput: one item per cycle if skid is free, set by the single update step
// a two-entry result buffer takes one more item while the output stalls
// reset: time clears to 00:00:00, the ring loads its two top leds, buffer empty
`timescale 1ns / 1ps
`default_nettype none

module settable_clock_with_led_rotator #(
  parameter int unsigned LED_COUNT = 10
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             rotate_left_i,
  input  wire logic [1:0]                       set_select_i,
  input  wire logic [6:0]                       set_value_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [scl_pkg::SEG_W-1:0]             seg_sec_ones_o,
  output logic [scl_pkg::SEG_W-1:0]             seg_sec_tens_o,
  output logic [scl_pkg::SEG_W-1:0]             seg_min_ones_o,
  output logic [scl_pkg::SEG_W-1:0]             seg_min_tens_o,
  output logic [scl_pkg::SEG_W-1:0]             seg_hour_ones_o,
  output logic [scl_pkg::SEG_W-1:0]             seg_hour_tens_o,
  output logic [scl_pkg::LED_OUT_W-1:0]         led_pattern_o
);
  import scl_pkg::*;

  logic                 step;
  logic                 skid_valid;
  time_t                time_q, time_d;
  logic [LED_OUT_W-1:0] led_cur;
  result_t              result_d, result_q;

  // an item is taken whenever the skid entry is free
  assign step = in_valid_i && in_ready_o;

  // state: advance, then set, then rotate the ring
  scl_tick #(
    .LED_COUNT (LED_COUNT)
  ) u_tick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rotate_left_i (rotate_left_i),
    .set_select_i  (set_select_i),
    .set_value_i   (set_value_i),
    .time_q_o      (time_q),
    .time_d_o      (time_d),
    .led_pattern_o (led_cur)
  );

  // display shows the post-update time; leds show the pre-rotation ring
  scl_seg_decode u_decode (
    .time_i        (time_d),
    .led_pattern_i (led_cur),
    .result_o      (result_d)
  );

  scl_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (step),
    .data_i       (result_d),
    .ready_o      (in_ready_o),
    .valid_o      (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .data_o       (result_q),
    .skid_valid_o (skid_valid)
  );

  assign seg_sec_ones_o  = result_q.seg_sec_ones;
  assign seg_sec_tens_o  = result_q.seg_sec_tens;
  assign seg_min_ones_o  = result_q.seg_min_ones;
  assign seg_min_tens_o  = result_q.seg_min_tens;
  assign seg_hour_ones_o = result_q.seg_hour_ones;
  assign seg_hour_tens_o = result_q.seg_hour_tens;
  assign led_pattern_o   = result_q.led_pattern;

  // skid entry is only ever filled behind a waiting result
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid |-> out_valid_o)
    else $error("skid entry holds an item with no result in front");

  // an accepted item is always followed by a valid result next cycle
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted item produced no result");

  // a stalled result is not dropped
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled result vanished");

  // time state stays within its ranges
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.sec < SEC_LIMIT) && (time_q.min < MIN_LIMIT) && (time_q.hour < HOUR_LIMIT))
    else $error("time state out of range");

endmodule

`default_nettype wire

@@ bench/settable_clock_with_led_rotator_tb.sv @@
// ----------------------------------------------------------------------------
// settable_clock_with_led_rotator_tb
// drives one-second ticks with directed and random switch states, checking
// all segment codes and the led pattern against a local model or typed row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module settable_clock_with_led_rotator_tb;

  import scl_pkg::*;

  localparam int unsigned RING_W         = 10;
  localparam int unsigned TICKS_PER_PHASE = 360;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STUCK_LIMIT    = 2000;
  // spare cycles waited once every owed display has arrived
  localparam int unsigned DRAIN_CYCLES   = 4;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    logic       rl;
    set_sel_e   sel;
    logic [6:0] val;
    bit         typed;
    result_t    want;
  } tick_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic                 rotate_left_i = 1'b0;
  logic [1:0]           set_select_i  = 2'd0;
  logic [6:0]           set_value_i   = 7'd0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [SEG_W-1:0]     seg_sec_ones_o;
  logic [SEG_W-1:0]     seg_sec_tens_o;
  logic [SEG_W-1:0]     seg_min_ones_o;
  logic [SEG_W-1:0]     seg_min_tens_o;
  logic [SEG_W-1:0]     seg_hour_ones_o;
  logic [SEG_W-1:0]     seg_hour_tens_o;
  logic [LED_OUT_W-1:0] led_pattern_o;

  // model of the clock state
  logic [5:0]        model_sec;
  logic [5:0]        model_min;
  logic [4:0]        model_hour;
  logic [RING_W-1:0] model_ring;

  result_t     display_q[$];   // displays still owed by the block
  tick_row_t   tick_table[$];
  int unsigned mismatch_count = 0;
  int unsigned shown_count    = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // typed expectation travelling with the item now on the input
  bit      row_typed = 1'b0;
  result_t row_want  = '0;

  settable_clock_with_led_rotator #(
    .LED_COUNT (RING_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rotate_left_i   (rotate_left_i),
    .set_select_i    (set_select_i),
    .set_value_i     (set_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .seg_sec_ones_o  (seg_sec_ones_o),
    .seg_sec_tens_o  (seg_sec_tens_o),
    .seg_min_ones_o  (seg_min_ones_o),
    .seg_min_tens_o  (seg_min_tens_o),
    .seg_hour_ones_o (seg_hour_ones_o),
    .seg_hour_tens_o (seg_hour_tens_o),
    .led_pattern_o   (led_pattern_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // active-low codes, bit 0 is segment a
  function automatic logic [6:0] segments_for(input int unsigned digit);
    logic [6:0] code;
    case (digit)
      1:       code = 7'h79;
      2:       code = 7'h24;
      3:       code = 7'h30;
      4:       code = 7'h19;
      5:       code = 7'h12;
      6:       code = 7'h02;
      7:       code = 7'h78;
      8:       code = 7'h00;
      9:       code = 7'h10;
      default: code = 7'h40;
    endcase
    return code;
  endfunction

  // one tick of the model: advance, rotate, set, then show the time
  task automatic advance_clock(input logic rl, input logic [1:0] sel,
                               input logic [6:0] val, output result_t shown);
    logic [RING_W-1:0] before_rot;
    before_rot = model_ring;

    // seconds roll into minutes, minutes into hours, hours wrap at 24
    if (model_sec == 6'd59) begin
      model_sec = 6'd0;
      if (model_min == 6'd59) begin
        model_min  = 6'd0;
        model_hour = (model_hour == 5'd23) ? 5'd0 : model_hour + 5'd1;
      end else begin
        model_min = model_min + 6'd1;
      end
    end else begin
      model_sec = model_sec + 6'd1;
    end

    // the bit leaving one end of the ring enters at the other
    if (rl) begin
      model_ring = {before_rot[RING_W-2:0], before_rot[RING_W-1]};
    end else begin
      model_ring = {before_rot[0], before_rot[RING_W-1:1]};
    end

    // set lands after the advance; an out-of-range value loads zero
    case (set_sel_e'(sel))
      SEL_SEC:  model_sec  = (val >= 7'd60) ? 6'd0 : val[5:0];
      SEL_MIN:  model_min  = (val >= 7'd60) ? 6'd0 : val[5:0];
      SEL_HOUR: model_hour = (val >= 7'd24) ? 5'd0 : val[4:0];
      default:  ;
    endcase

    shown.seg_sec_ones  = segments_for(model_sec % 10);
    shown.seg_sec_tens  = segments_for(model_sec / 10);
    shown.seg_min_ones  = segments_for(model_min % 10);
    shown.seg_min_tens  = segments_for(model_min / 10);
    shown.seg_hour_ones = segments_for(model_hour % 10);
    shown.seg_hour_tens = segments_for(model_hour / 10);
    shown.led_pattern   = before_rot;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned idx,
                             input logic [9:0] got, input logic [9:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("display %0d %s got %h want %h", idx, name, got, want));
    end
  endtask

  // input and output handshakes, both sampled at the rising edge
  always @(posedge clk_i) begin : handshake_monitor
    result_t predicted;
    result_t owed;
    predicted = '0;
    owed      = '0;

    if (in_valid_i && in_ready_o) begin
      advance_clock(rotate_left_i, set_select_i, set_value_i, predicted);
      // typed rows carry their own answer, the model still steps
      display_q.push_back(row_typed ? row_want : predicted);
    end

    if (out_valid_o && out_ready_i) begin
      if (display_q.size() == 0) begin
        report_mismatch($sformatf("display %0d arrived with nothing owed", shown_count));
      end else begin
        owed = display_q.pop_front();
        check_field("seg_sec_ones",  shown_count, 10'(seg_sec_ones_o),  10'(owed.seg_sec_ones));
        check_field("seg_sec_tens",  shown_count, 10'(seg_sec_tens_o),  10'(owed.seg_sec_tens));
        check_field("seg_min_ones",  shown_count, 10'(seg_min_ones_o),  10'(owed.seg_min_ones));
        check_field("seg_min_tens",  shown_count, 10'(seg_min_tens_o),  10'(owed.seg_min_tens));
        check_field("seg_hour_ones", shown_count, 10'(seg_hour_ones_o), 10'(owed.seg_hour_ones));
        check_field("seg_hour_tens", shown_count, 10'(seg_hour_tens_o), 10'(owed.seg_hour_tens));
        check_field("led_pattern",   shown_count, 10'(led_pattern_o),   10'(owed.led_pattern));
      end
      shown_count++;
    end

    // hang detector only runs once reset is released
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
  end

  // receiver backpressure, rolled fresh every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // present one item and hold it until the block takes it
  task automatic drive_tick(input logic rl, input set_sel_e sel, input logic [6:0] val,
                            input bit typed, input result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    row_typed = typed;
    row_want  = want;
    in_valid_i    <= 1'b1;
    rotate_left_i <= rl;
    set_select_i  <= sel;
    set_value_i   <= val;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic rl, input set_sel_e sel, input logic [6:0] val);
    tick_table.push_back('{rl: rl, sel: sel, val: val, typed: 1'b0, want: '0});
  endtask

  task automatic add_typed(input logic rl, input set_sel_e sel, input logic [6:0] val,
                           input result_t want);
    tick_table.push_back('{rl: rl, sel: sel, val: val, typed: 1'b1, want: want});
  endtask

  // values near the limits come up often so the rollovers get exercised
  function automatic logic [6:0] pick_value(input set_sel_e sel);
    logic [6:0] v;
    case ($urandom_range(0, 3))
      0: v = 7'($urandom_range(0, 127));
      1: begin
        case ($urandom_range(0, 6))
          0:       v = 7'd0;
          1:       v = 7'd23;
          2:       v = 7'd24;
          3:       v = 7'd58;
          4:       v = 7'd59;
          5:       v = 7'd60;
          default: v = 7'd127;
        endcase
      end
      default: v = (sel == SEL_HOUR) ? 7'($urandom_range(0, 23)) : 7'($urandom_range(0, 59));
    endcase
    return v;
  endfunction

  function automatic set_sel_e pick_select();
    return ($urandom_range(0, 4) < 2) ? SEL_NONE : set_sel_e'($urandom_range(1, 3));
  endfunction

  initial begin : stimulus
    int unsigned sent;
    set_sel_e    sel;
    model_sec  = 6'd0;
    model_min  = 6'd0;
    model_hour = 5'd0;
    model_ring = 10'h300;

    // first tick after reset, then climb to 23:59 by sets
    add_typed(1'b0, SEL_NONE, 7'd0,
              '{7'h79, 7'h40, 7'h40, 7'h40, 7'h40, 7'h40, 10'h300});
    add_typed(1'b1, SEL_SEC, 7'd59,
              '{7'h10, 7'h12, 7'h40, 7'h40, 7'h40, 7'h40, 10'h180});
    // seconds roll first, then minutes are set; left rotation wraps bit 9
    add_typed(1'b1, SEL_MIN, 7'd59,
              '{7'h40, 7'h40, 7'h10, 7'h12, 7'h40, 7'h40, 10'h300});
    add_typed(1'b1, SEL_HOUR, 7'd23,
              '{7'h79, 7'h40, 7'h10, 7'h12, 7'h30, 7'h24, 10'h201});
    // right rotation wraps bit 0 into the top
    add_row(1'b0, SEL_SEC,  7'd58);
    add_row(1'b0, SEL_NONE, 7'd127);
    add_row(1'b1, SEL_NONE, 7'd0);     // full rollover to midnight
    // out-of-range sets load zero, then in-range sets of zero
    add_row(1'b0, SEL_SEC,  7'd60);
    add_row(1'b1, SEL_SEC,  7'd127);
    add_row(1'b0, SEL_MIN,  7'd60);
    add_row(1'b1, SEL_MIN,  7'd127);
    add_row(1'b0, SEL_HOUR, 7'd24);
    add_row(1'b1, SEL_HOUR, 7'd127);
    add_row(1'b0, SEL_HOUR, 7'd0);
    add_row(1'b1, SEL_MIN,  7'd0);
    add_row(1'b0, SEL_SEC,  7'd0);
    // a set right after a minute rollover wins
    add_row(1'b1, SEL_SEC,  7'd59);
    add_row(1'b0, SEL_MIN,  7'd30);
    // a set right after an hour rollover wins
    add_row(1'b1, SEL_MIN,  7'd59);
    add_row(1'b0, SEL_SEC,  7'd59);
    add_row(1'b1, SEL_HOUR, 7'd5);
    add_row(1'b0, SEL_NONE, 7'd0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (tick_table[i]) begin
      drive_tick(tick_table[i].rl, tick_table[i].sel, tick_table[i].val,
                 tick_table[i].typed, tick_table[i].want);
    end

    // phases: free flow, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        // now and then try to park at 23:59:59 so the next tick wraps the day
        if ($urandom_range(0, 19) == 0) begin
          drive_tick(1'($urandom), SEL_HOUR, 7'd23, 1'b0, '0);
          drive_tick(1'($urandom), SEL_MIN,  7'd59, 1'b0, '0);
          drive_tick(1'($urandom), SEL_SEC,  7'd59, 1'b0, '0);
          sent += 3;
        end
        sel = pick_select();
        drive_tick(1'($urandom), sel, pick_value(sel), 1'b0, '0);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (display_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // no handshake for too long means the block is hung
  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/scl_pkg.sv
rtl/scl_tick.sv
rtl/scl_seg_decode.sv
rtl/scl_out_buf.sv
rtl/settable_clock_with_led_rotator.sv
bench/settable_clock_with_led_rotator_tb.sv
